/* rtl/hhbc_pkg.sv */
// ----------------------------------------------------------------------------
// HTTP header block checker package
// Shared codes, character constants and the per-word step result type.
// ----------------------------------------------------------------------------
package hhbc_pkg;

   // Parse phases.
   localparam logic [2:0] PH_FIRST     = 3'd0;
   localparam logic [2:0] PH_KEY       = 3'd1;
   localparam logic [2:0] PH_SPACE     = 3'd2;
   localparam logic [2:0] PH_VALUE     = 3'd3;
   localparam logic [2:0] PH_LF        = 3'd4;
   localparam logic [2:0] PH_LINESTART = 3'd5;
   localparam logic [2:0] PH_TERM_LF   = 3'd6;
   localparam logic [2:0] PH_DONE      = 3'd7;

   // Byte classes.
   localparam logic [2:0] CL_KEY    = 3'd0;
   localparam logic [2:0] CL_COLON  = 3'd1;
   localparam logic [2:0] CL_SPACE  = 3'd2;
   localparam logic [2:0] CL_VALUE  = 3'd3;
   localparam logic [2:0] CL_LINE   = 3'd4;
   localparam logic [2:0] CL_TERM   = 3'd5;
   localparam logic [2:0] CL_IGNORE = 3'd6;
   localparam logic [2:0] CL_BAD    = 3'd7;

   // Verdicts.
   localparam logic [1:0] V_PARSING  = 2'd0;
   localparam logic [1:0] V_ACCEPTED = 2'd1;
   localparam logic [1:0] V_REJECTED = 2'd2;

   // Characters.
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_HYPHEN = 8'h2D;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   // Outcome of one byte: next state plus the fields to report.
   typedef struct packed {
      logic [2:0] phase;
      logic [1:0] verdict;
      logic [2:0] byte_class;
      logic [1:0] rsp_verdict;
   } step_result_type;

   // ASCII letters only.
   function automatic logic is_alpha(input logic [7:0] b);
      is_alpha = ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
   endfunction

endpackage

/* rtl/hhbc_step.sv */
// ----------------------------------------------------------------------------
// HTTP header block checker step logic
// Classifies one byte against the current phase and gives the next state.
// ----------------------------------------------------------------------------
module hhbc_step (
   input  logic [2:0]               phase,
   input  logic [1:0]               verdict,
   input  logic [7:0]               data_byte,
   input  logic                     last_byte,
   output hhbc_pkg::step_result_type result
);
   import hhbc_pkg::*;

   logic [2:0] phase_n;
   logic [1:0] verdict_n;
   logic [2:0] cls;
   logic       key_char;
   logic [1:0] verdict_out;

   assign key_char = is_alpha(data_byte) || (data_byte == CH_HYPHEN);

   // Phase transition and byte class; any rule break rejects at once.
   always_comb begin
      phase_n   = phase;
      verdict_n = verdict;
      cls       = CL_BAD;
      case (phase)
         PH_FIRST: begin
            if (is_alpha(data_byte)) begin
               cls     = CL_KEY;
               phase_n = PH_KEY;
            end else begin
               phase_n   = PH_DONE;
               verdict_n = V_REJECTED;
            end
         end
         PH_KEY: begin
            if (key_char) begin
               cls = CL_KEY;
            end else if (data_byte == CH_COLON) begin
               cls     = CL_COLON;
               phase_n = PH_SPACE;
            end else begin
               phase_n   = PH_DONE;
               verdict_n = V_REJECTED;
            end
         end
         PH_SPACE: begin
            if (data_byte == CH_SPACE) begin
               cls = CL_SPACE;
            end else if (data_byte == CH_CR) begin
               cls     = CL_LINE;
               phase_n = PH_LF;
            end else begin
               cls     = CL_VALUE;
               phase_n = PH_VALUE;
            end
         end
         PH_VALUE: begin
            if (data_byte == CH_CR) begin
               cls     = CL_LINE;
               phase_n = PH_LF;
            end else begin
               cls = CL_VALUE;
            end
         end
         PH_LF: begin
            if (data_byte == CH_LF) begin
               cls     = CL_LINE;
               phase_n = PH_LINESTART;
            end else begin
               phase_n   = PH_DONE;
               verdict_n = V_REJECTED;
            end
         end
         PH_LINESTART: begin
            if (data_byte == CH_CR) begin
               cls     = CL_TERM;
               phase_n = PH_TERM_LF;
            end else if (key_char) begin
               cls     = CL_KEY;
               phase_n = PH_KEY;
            end else if (data_byte == CH_COLON) begin
               cls     = CL_COLON;
               phase_n = PH_SPACE;
            end else begin
               phase_n   = PH_DONE;
               verdict_n = V_REJECTED;
            end
         end
         PH_TERM_LF: begin
            if (data_byte == CH_LF) begin
               cls       = CL_TERM;
               phase_n   = PH_DONE;
               verdict_n = V_ACCEPTED;
            end else begin
               phase_n   = PH_DONE;
               verdict_n = V_REJECTED;
            end
         end
         default: begin
            cls = CL_IGNORE;
         end
      endcase
   end

   // A buffer that ends while still parsing is rejected.
   assign verdict_out = (last_byte && (verdict_n == V_PARSING)) ? V_REJECTED : verdict_n;

   // After the final byte the state goes back to start.
   always_comb begin
      result.byte_class  = cls;
      result.rsp_verdict = verdict_out;
      if (last_byte) begin
         result.phase   = PH_FIRST;
         result.verdict = V_PARSING;
      end else begin
         result.phase   = phase_n;
         result.verdict = verdict_n;
      end
   end

endmodule

/* rtl/hhbc_out_reg.sv */
// ----------------------------------------------------------------------------
// HTTP header block checker output register
// Holds one result word and decouples the two sides of the stream.
// ----------------------------------------------------------------------------
module hhbc_out_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  logic [2:0] byte_class,
   input  logic [1:0] verdict,
   input  logic       end_of_buffer,
   output logic       can_load,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tlast
);
   import hhbc_pkg::*;

   logic       valid_ff, valid_in;
   logic [2:0] class_ff;
   logic [1:0] verdict_ff;
   logic       last_ff;

   // A new word may enter when the register is empty or is being drained.
   assign can_load = !valid_ff || rsp_tready;
   assign valid_in = load ? 1'b1 : (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (load) begin
         class_ff   <= byte_class;
         verdict_ff <= verdict;
         last_ff    <= end_of_buffer;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {3'b000, verdict_ff, class_ff};
   assign rsp_tlast  = last_ff;

endmodule

/* rtl/http_header_block_checker.sv */
// ----------------------------------------------------------------------------
// HTTP header block checker
// Validates an HTTP header block one byte per word and reports per byte.
// ----------------------------------------------------------------------------
// The block takes one header byte per word and returns one result word per
// byte, registered in the cycle after it is accepted, at one byte per clock
// while the receiver takes results: the next state is combinational and a new
// byte may enter as the output register is emptied or while it is empty.
// A buffer ends with tlast on its final byte; that result carries tlast and
// the final verdict, and the parser then returns to its start state.
module http_header_block_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [2:0] byte_class, [4:3] verdict, [7:5] zero
   output logic       rsp_tlast    // end_of_buffer
);
   import hhbc_pkg::*;

   logic [2:0]      phase_ff, phase_in;
   logic [1:0]      verdict_ff, verdict_in;
   logic            accept;
   logic            can_load;
   step_result_type step;

   assign req_tready = can_load;
   assign accept     = req_tvalid && can_load;

   // Byte classification and next state.
   hhbc_step u_step (
      .phase     (phase_ff),
      .verdict   (verdict_ff),
      .data_byte (req_tdata),
      .last_byte (req_tlast),
      .result    (step)
   );

   // Parser state advances on each accepted word.
   assign phase_in   = accept ? step.phase   : phase_ff;
   assign verdict_in = accept ? step.verdict : verdict_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_FIRST;
         verdict_ff <= V_PARSING;
      end else begin
         phase_ff   <= phase_in;
         verdict_ff <= verdict_in;
      end
   end

   // Result register.
   hhbc_out_reg u_out (
      .clock         (clock),
      .reset         (reset),
      .load          (accept),
      .byte_class    (step.byte_class),
      .verdict       (step.rsp_verdict),
      .end_of_buffer (req_tlast),
      .can_load      (can_load),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast)
   );

endmodule

/* rtl/hhbc_checker.sv */
// ----------------------------------------------------------------------------
// HTTP header block checker assertions
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module hhbc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);
   import hhbc_pkg::*;

   // A stalled result word holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // Every accepted byte shows a result in the next cycle.
   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("accepted byte produced no result");

   // The final byte of a buffer always carries a settled verdict.
   a_last_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[4:3] == V_ACCEPTED || rsp_tdata[4:3] == V_REJECTED)
      else $error("final byte reported still parsing");

   // Ignored and offending bytes only appear once a verdict is settled.
   a_class_verdict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] == CL_IGNORE || rsp_tdata[2:0] == CL_BAD)
         |-> rsp_tdata[4:3] != V_PARSING)
      else $error("ignored or offending byte without a verdict");

   // Padding bits stay zero and the verdict code is legal.
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:5] == 3'b000 && rsp_tdata[4:3] != 2'd3)
      else $error("malformed result word");

endmodule

bind http_header_block_checker hhbc_checker u_hhbc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP header block checker testbench
// Feeds header buffers byte by byte, predicts the class and verdict of every
// byte, and checks each result word in order under random idling.
// ----------------------------------------------------------------------------
module testbench;
   import hhbc_pkg::*;

   localparam int CLOCK_HALF  = 10;
   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_REPORTS = 10;
   localparam int IDLE_PCT    = 21;

   // What one result word should carry.
   typedef struct packed {
      logic [2:0] byte_class;
      logic [1:0] verdict;
      logic       end_of_buffer;
   } byte_report_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;

   byte_report_type expected_reports[$];
   logic [7:0]      block_bytes[$];

   // Parser state of the prediction.
   logic [2:0] hdr_phase;
   logic [1:0] hdr_verdict;

   int sender_idle_pct;
   int receiver_idle_pct;
   int hold_left;
   int mismatch_count;
   int bytes_sent;
   int buffers_sent;
   int accepted_buffers;
   int rejected_buffers;
   int results_seen;
   int unsigned cycle_count;

   http_header_block_checker i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #(CLOCK_HALF) clock = ~clock;

   // Give up on a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still expected.",
                  cycle_count, expected_reports.size());
         $display("testbench NOT OK");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   function automatic logic is_ascii_letter(input logic [7:0] b);
      return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
   endfunction

   // A byte that breaks the grammar rejects the whole block.
   task automatic mark_offending(output logic [2:0] cls);
      cls         = CL_BAD;
      hdr_phase   = PH_DONE;
      hdr_verdict = V_REJECTED;
   endtask

   // Advance the parser by one accepted byte and queue the word it must give.
   task automatic parse_header_byte(input logic [7:0] b, input logic last);
      logic [2:0]      cls;
      logic            key_char;
      byte_report_type report;
      key_char = is_ascii_letter(b) || (b == CH_HYPHEN);
      case (hdr_phase)
         PH_FIRST: begin
            if (is_ascii_letter(b)) begin
               cls       = CL_KEY;
               hdr_phase = PH_KEY;
            end else mark_offending(cls);
         end
         PH_KEY: begin
            if (key_char) cls = CL_KEY;
            else if (b == CH_COLON) begin
               cls       = CL_COLON;
               hdr_phase = PH_SPACE;
            end else mark_offending(cls);
         end
         PH_SPACE: begin
            if (b == CH_SPACE) cls = CL_SPACE;
            else if (b == CH_CR) begin
               cls       = CL_LINE;
               hdr_phase = PH_LF;
            end else begin
               cls       = CL_VALUE;
               hdr_phase = PH_VALUE;
            end
         end
         PH_VALUE: begin
            if (b == CH_CR) begin
               cls       = CL_LINE;
               hdr_phase = PH_LF;
            end else cls = CL_VALUE;
         end
         PH_LF: begin
            if (b == CH_LF) begin
               cls       = CL_LINE;
               hdr_phase = PH_LINESTART;
            end else mark_offending(cls);
         end
         PH_LINESTART: begin
            if (b == CH_CR) begin
               cls       = CL_TERM;
               hdr_phase = PH_TERM_LF;
            end else if (key_char) begin
               cls       = CL_KEY;
               hdr_phase = PH_KEY;
            end else if (b == CH_COLON) begin
               cls       = CL_COLON;
               hdr_phase = PH_SPACE;
            end else mark_offending(cls);
         end
         PH_TERM_LF: begin
            if (b == CH_LF) begin
               cls         = CL_TERM;
               hdr_phase   = PH_DONE;
               hdr_verdict = V_ACCEPTED;
            end else mark_offending(cls);
         end
         default: cls = CL_IGNORE;
      endcase

      // A buffer that stops before a verdict is rejected on its final byte.
      if (last && (hdr_verdict == V_PARSING)) hdr_verdict = V_REJECTED;

      report.byte_class    = cls;
      report.verdict       = hdr_verdict;
      report.end_of_buffer = last;
      expected_reports.push_back(report);

      if (last) begin
         buffers_sent++;
         if (hdr_verdict == V_ACCEPTED) accepted_buffers++;
         else rejected_buffers++;
         hdr_phase   = PH_FIRST;
         hdr_verdict = V_PARSING;
      end
   endtask

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------

   task automatic note_mismatch(input string field, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("Mismatch at result word %0d, %s: expected %0d, got %0d",
                  results_seen, field, want, got);
   endtask

   always @(posedge clock) begin : check_results
      byte_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_reports.size() == 0) begin
            note_mismatch("word with nothing expected", 0, rsp_tdata);
         end else begin
            want = expected_reports.pop_front();
            if (rsp_tdata[2:0] != want.byte_class)
               note_mismatch("byte class", want.byte_class, rsp_tdata[2:0]);
            if (rsp_tdata[4:3] != want.verdict)
               note_mismatch("verdict", want.verdict, rsp_tdata[4:3]);
            if (rsp_tdata[7:5] != 3'd0)
               note_mismatch("padding bits", 0, rsp_tdata[7:5]);
            if (rsp_tlast != want.end_of_buffer)
               note_mismatch("end of buffer", want.end_of_buffer, rsp_tlast);
         end
         results_seen++;
      end
   end

   // Receiver: random stalls, or a counted hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready = 1'b0;
         hold_left--;
      end else begin
         rsp_tready = ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Offer one byte, with random idle cycles first, and wait for the handshake.
   task automatic send_byte(input logic [7:0] b, input logic last);
      @(negedge clock);
      while ((sender_idle_pct != 0) && ($urandom_range(99) < sender_idle_pct)) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = b;
      req_tlast  = last;
      do @(posedge clock); while (!req_tready);
      parse_header_byte(b, last);
      bytes_sent++;
   endtask

   task automatic stop_requests();
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic wait_for_drain();
      stop_requests();
      while (expected_reports.size() != 0) @(posedge clock);
   endtask

   task automatic queue_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) block_bytes.push_back(s[i]);
   endtask

   // Send the staged buffer, marking its final byte.
   task automatic send_block();
      int i;
      for (i = 0; i < block_bytes.size(); i++)
         send_byte(block_bytes[i], i == block_bytes.size() - 1);
      block_bytes.delete();
   endtask

   function automatic logic [7:0] random_letter();
      return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'($urandom_range(25));
   endfunction

   function automatic logic [7:0] random_key_char();
      return ($urandom_range(7) == 0) ? CH_HYPHEN : random_letter();
   endfunction

   // Bytes near the grammar's edges: delimiters and the neighbors of the letters.
   function automatic logic [7:0] tricky_byte();
      case ($urandom_range(9))
         0:       return CH_CR;
         1:       return CH_LF;
         2:       return CH_COLON;
         3:       return CH_SPACE;
         4:       return CH_HYPHEN;
         5:       return 8'h40;
         6:       return 8'h5B;
         7:       return 8'h60;
         8:       return 8'h7B;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // A valid header block with random keys, spacing, values and trailing bytes.
   task automatic build_well_formed_block();
      int lines;
      int line;
      int n;
      int k;
      logic [7:0] b;
      lines = $urandom_range(4, 1);
      for (line = 0; line < lines; line++) begin
         n = (line == 0) ? $urandom_range(6, 1) : $urandom_range(6, 0);
         for (k = 0; k < n; k++)
            block_bytes.push_back(((line == 0) && (k == 0)) ? random_letter()
                                                            : random_key_char());
         block_bytes.push_back(CH_COLON);
         n = $urandom_range(3, 0);
         for (k = 0; k < n; k++) block_bytes.push_back(CH_SPACE);
         n = $urandom_range(6, 0);
         for (k = 0; k < n; k++) begin
            do b = 8'($urandom_range(255)); while (b == CH_CR);
            block_bytes.push_back(b);
         end
         block_bytes.push_back(CH_CR);
         block_bytes.push_back(CH_LF);
      end
      block_bytes.push_back(CH_CR);
      block_bytes.push_back(CH_LF);
      n = $urandom_range(3, 0);
      for (k = 0; k < n; k++) block_bytes.push_back(8'($urandom_range(255)));
   endtask

   // Mostly valid blocks, some damaged or cut short, the rest plain noise.
   task automatic build_random_block();
      int n;
      int k;
      if ($urandom_range(99) < 70) begin
         build_well_formed_block();
         if ($urandom_range(99) < 20)
            block_bytes[$urandom_range(block_bytes.size() - 1)] = tricky_byte();
         if ($urandom_range(99) < 15) begin
            n = $urandom_range(block_bytes.size(), 1);
            while (block_bytes.size() > n) void'(block_bytes.pop_back());
         end
      end else begin
         n = $urandom_range(10, 1);
         for (k = 0; k < n; k++)
            block_bytes.push_back($urandom_range(1) ? tricky_byte() : random_letter());
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Every class, empty key and value, high bytes and the early-end cases.
   // CR and LF are written as octal escapes.
   task automatic test_directed_cases();
      // Full block with hyphen key, empty value, empty key and trailing byte.
      queue_text("A-:\015\012: z\015\012\015\012");
      block_bytes.push_back(8'hFF);
      send_block();
      // Buffer that ends after a single key letter.
      queue_text("Z");
      send_block();
      // CR inside a line not followed by LF.
      queue_text("a:\015X");
      send_block();
      // A letter with the top bit set is no letter; the next byte is ignored.
      block_bytes.push_back(8'hC1);
      block_bytes.push_back(8'h00);
      send_block();
      // CR at line start not followed by LF.
      queue_text("k:v\015\012\015-");
      send_block();
   endtask

   task automatic test_random_buffers(input int n_bytes);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) begin
         build_random_block();
         send_block();
      end
   endtask

   // Back to back words on both sides.
   task automatic test_full_rate_stream();
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      test_random_buffers(300);
      sender_idle_pct   = IDLE_PCT;
      receiver_idle_pct = IDLE_PCT;
   endtask

   // The receiver stops while the sender keeps offering, so the input stalls.
   task automatic test_receiver_hold_off();
      int k;
      sender_idle_pct = 0;
      hold_left       = 60;
      for (k = 0; k < 3; k++) begin
         build_well_formed_block();
         send_block();
      end
      sender_idle_pct = IDLE_PCT;
   endtask

   // The sender waits for every outstanding result between buffers.
   task automatic test_pause_between_buffers();
      int k;
      for (k = 0; k < 4; k++) begin
         build_random_block();
         send_block();
         wait_for_drain();
      end
   endtask

   initial begin
      reset             = 1'b1;
      req_tvalid        = 1'b0;
      req_tdata         = 8'h00;
      req_tlast         = 1'b0;
      rsp_tready        = 1'b0;
      hdr_phase         = PH_FIRST;
      hdr_verdict       = V_PARSING;
      sender_idle_pct   = IDLE_PCT;
      receiver_idle_pct = IDLE_PCT;
      hold_left         = 0;
      mismatch_count    = 0;
      bytes_sent        = 0;
      buffers_sent      = 0;
      accepted_buffers  = 0;
      rejected_buffers  = 0;
      results_seen      = 0;
      cycle_count       = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_full_rate_stream();
      test_receiver_hold_off();
      test_pause_between_buffers();
      test_random_buffers(1700);

      wait_for_drain();
      repeat (4) @(posedge clock);

      $display("Sent %0d bytes in %0d buffers and checked %0d result words.",
               bytes_sent, buffers_sent, results_seen);
      $display("Buffers accepted: %0d, rejected: %0d, mismatches: %0d.",
               accepted_buffers, rejected_buffers, mismatch_count);
      if (mismatch_count == 0) $display("testbench OK");
      else $display("testbench NOT OK");
      $finish;
   end

endmodule
